[hw/rtl/dvrt_pkg.sv]
`timescale 1ns / 1ps

package dvrt_pkg;

  // Table geometry, fixed by the field widths of the item ports.
  localparam int unsigned MAX_NODES  = 16;
  localparam int unsigned NODE_W     = $clog2(MAX_NODES);
  localparam int unsigned NODE_CNT_W = 5;
  localparam int unsigned SRC_W      = 5;
  localparam int unsigned COST_BITS  = 8;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned AGE_BITS   = 16;
  localparam int unsigned REACH_W    = 5;
  localparam int unsigned KIND_W     = 2;

  localparam logic [REACH_W-1:0] REACH_MAX = '1;

  // APB register file.
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_SELF_ID    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COST_LIMIT = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT    = 2'd3;

  localparam logic [NODE_W-1:0]     RST_SELF_ID    = '0;
  localparam logic [NODE_CNT_W-1:0] RST_NODE_COUNT = NODE_CNT_W'(MAX_NODES);
  localparam logic [COST_BITS-1:0]  RST_COST_LIMIT = '1;
  localparam logic [TIMEOUT_W-1:0]  RST_TIMEOUT    = 16'd10;

  // Item kinds; the unused code behaves as a query.
  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0]     self_id;
    logic [NODE_CNT_W-1:0] node_count;
    logic [COST_BITS-1:0]  cost_limit;
    logic [TIMEOUT_W-1:0]  timeout_ticks;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic walk_step;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_tick;
    logic walk_last;
  } dp_status_t;

endpackage

[hw/rtl/dvrt_cfg.sv]
`timescale 1ns / 1ps

module dvrt_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dvrt_pkg::APB_AW-1:0]    paddr,
  input  logic [dvrt_pkg::APB_DW-1:0]    pwdata,
  output logic [dvrt_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  output dvrt_pkg::cfg_t                 cfg_o
);

  dvrt_pkg::cfg_t                   cfg_q;
  logic [dvrt_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[dvrt_pkg::APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.self_id       <= dvrt_pkg::RST_SELF_ID;
      cfg_q.node_count    <= dvrt_pkg::RST_NODE_COUNT;
      cfg_q.cost_limit    <= dvrt_pkg::RST_COST_LIMIT;
      cfg_q.timeout_ticks <= dvrt_pkg::RST_TIMEOUT;
    end else if (wr_en) begin
      case (reg_idx)
        dvrt_pkg::REG_SELF_ID:
          cfg_q.self_id <= pwdata[dvrt_pkg::NODE_W-1:0];
        dvrt_pkg::REG_NODE_COUNT:
          cfg_q.node_count <= pwdata[dvrt_pkg::NODE_CNT_W-1:0];
        dvrt_pkg::REG_COST_LIMIT:
          cfg_q.cost_limit <= pwdata[dvrt_pkg::COST_BITS-1:0];
        dvrt_pkg::REG_TIMEOUT:
          cfg_q.timeout_ticks <= pwdata[dvrt_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dvrt_pkg::REG_SELF_ID:    prdata = dvrt_pkg::APB_DW'(cfg_q.self_id);
      dvrt_pkg::REG_NODE_COUNT: prdata = dvrt_pkg::APB_DW'(cfg_q.node_count);
      dvrt_pkg::REG_COST_LIMIT: prdata = dvrt_pkg::APB_DW'(cfg_q.cost_limit);
      dvrt_pkg::REG_TIMEOUT:    prdata = dvrt_pkg::APB_DW'(cfg_q.timeout_ticks);
      default:                  prdata = '0;
    endcase
  end

endmodule

[hw/rtl/dvrt_ctrl.sv]
`timescale 1ns / 1ps

module dvrt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  dvrt_pkg::dp_status_t status_i,
  output dvrt_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d           = state_q;
    cmd_o.capture     = 1'b0;
    cmd_o.walk_step   = 1'b0;
    cmd_o.finish      = 1'b0;
    out_valid_d       = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = status_i.in_tick ? ST_WALK : ST_FINISH;
        end
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.walk_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Commit only once the output register can take the result.
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hw/rtl/dvrt_dp.sv]
`timescale 1ns / 1ps

module dvrt_dp #(
  parameter int unsigned AGE_BITS = dvrt_pkg::AGE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dvrt_pkg::cfg_t                    cfg_i,
  input  dvrt_pkg::dp_cmd_t                 cmd_i,
  output dvrt_pkg::dp_status_t              status_o,
  input  logic [dvrt_pkg::KIND_W-1:0]       kind_i,
  input  logic [dvrt_pkg::SRC_W-1:0]        source_id_i,
  input  logic [dvrt_pkg::NODE_W-1:0]       dest_id_i,
  input  logic [dvrt_pkg::COST_BITS-1:0]    adv_cost_i,
  input  logic                              last_entry_i,
  output logic                              changed_o,
  output logic [dvrt_pkg::COST_BITS-1:0]    route_cost_o,
  output logic [dvrt_pkg::NODE_W-1:0]       next_hop_o,
  output logic                              route_valid_o,
  output logic                              bridge_o,
  output logic                              ignored_o
);

  localparam int unsigned NN   = dvrt_pkg::MAX_NODES;
  localparam int unsigned NW   = dvrt_pkg::NODE_W;
  localparam int unsigned CW   = dvrt_pkg::COST_BITS;
  localparam int unsigned NCW  = dvrt_pkg::NODE_CNT_W;
  localparam int unsigned RW   = dvrt_pkg::REACH_W;
  localparam int unsigned TW   = dvrt_pkg::TIMEOUT_W;
  localparam int unsigned CMPW = (AGE_BITS > TW) ? AGE_BITS : TW;

  // Route table and per-node state.
  logic [CW-1:0]       cost_q   [NN];
  logic [NW-1:0]       hop_q    [NN];
  logic [NN-1:0]       valid_q;
  logic [AGE_BITS-1:0] age_q    [NN];
  logic [NN-1:0]       bridge_q;
  logic [RW-1:0]       reach_q;

  // Captured item.
  logic [dvrt_pkg::KIND_W-1:0] kind_q;
  logic [dvrt_pkg::SRC_W-1:0]  src_q;
  logic [NW-1:0]               dst_q;
  logic [CW-1:0]               adv_q;
  logic                        last_q;

  // Tick walk.
  logic [NW-1:0] idx_q;
  logic          tick_chg_q;

  // Result register.
  logic          res_changed_q;
  logic [CW-1:0] res_cost_q;
  logic [NW-1:0] res_hop_q;
  logic          res_valid_q;
  logic          res_bridge_q;
  logic          res_ignored_q;

  logic [NCW-1:0]      n_act;
  logic                is_entry, is_tick, is_query;
  logic                entry_ok;
  logic [NW-1:0]       src_idx;
  logic                dst_in, dst_self;
  logic [CW:0]         cand_wide;
  logic [CW-1:0]       cand;
  logic                upd;
  logic [RW-1:0]       reach_inc;
  logic                bridge_new;
  logic                wnode_act;
  logic [AGE_BITS-1:0] age_cur, age_inc;
  logic                timed;
  logic [NN-1:0]       drop;
  logic                res_changed;
  logic [CW-1:0]       res_cost;
  logic [NW-1:0]       res_hop;
  logic                res_valid;
  logic                res_bridge;

  assign status_o.in_tick   = (kind_i == dvrt_pkg::KIND_TICK);
  assign status_o.walk_last = (idx_q == NW'(NN - 1));

  always_comb begin
    n_act = (cfg_i.node_count > NCW'(NN)) ? NCW'(NN) : cfg_i.node_count;

    is_entry = (kind_q == dvrt_pkg::KIND_ENTRY);
    is_tick  = (kind_q == dvrt_pkg::KIND_TICK);
    is_query = !is_entry && !is_tick;

    entry_ok = is_entry && (NCW'(src_q) < n_act);
    src_idx  = src_q[NW-1:0];
    dst_in   = (NCW'(dst_q) < n_act);
    dst_self = (dst_q == cfg_i.self_id);

    // Relax: advertised cost plus one hop, clamped to infinity.
    cand_wide = {1'b0, adv_q} + (CW + 1)'(1);
    cand      = (cand_wide > {1'b0, cfg_i.cost_limit}) ? cfg_i.cost_limit : cand_wide[CW-1:0];
    upd       = entry_ok && dst_in && !dst_self && (cand < cost_q[dst_q]);

    reach_inc  = ((adv_q <= CW'(1)) && (reach_q != dvrt_pkg::REACH_MAX)) ?
                 reach_q + RW'(1) : reach_q;
    bridge_new = (({1'b0, reach_inc} + (RW + 1)'(1)) >= (RW + 1)'(n_act));

    // One node of the tick walk per cycle.
    wnode_act = (NCW'(idx_q) < n_act) && (idx_q != cfg_i.self_id);
    age_cur   = age_q[idx_q];
    age_inc   = (age_cur == '1) ? age_cur : age_cur + AGE_BITS'(1);
    timed     = wnode_act && (CMPW'(age_inc) > CMPW'(cfg_i.timeout_ticks));
    for (int j = 0; j < NN; j++) begin
      drop[j] = timed && valid_q[j] && (hop_q[j] == idx_q) &&
                (NCW'(j) < n_act) && (NW'(j) != cfg_i.self_id);
    end

    // Result as seen after this item.
    if (dst_self) begin
      res_cost  = '0;
      res_hop   = cfg_i.self_id;
      res_valid = 1'b1;
    end else if (dst_in) begin
      res_cost  = upd ? cand : cost_q[dst_q];
      res_hop   = upd ? src_idx : hop_q[dst_q];
      res_valid = upd ? 1'b1 : valid_q[dst_q];
    end else begin
      res_cost  = cfg_i.cost_limit;
      res_hop   = '0;
      res_valid = 1'b0;
    end
    res_changed = upd || (is_tick && tick_chg_q);
    res_bridge  = (entry_ok && last_q && bridge_new) || (is_query && bridge_q[dst_q]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      src_q  <= source_id_i;
      dst_q  <= dest_id_i;
      adv_q  <= adv_cost_i;
      last_q <= last_entry_i;
    end
    if (cmd_i.finish) begin
      res_changed_q <= res_changed;
      res_cost_q    <= res_cost;
      res_hop_q     <= res_hop;
      res_valid_q   <= res_valid;
      res_bridge_q  <= res_bridge;
      res_ignored_q <= is_entry && !entry_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      tick_chg_q <= 1'b0;
    end else if (cmd_i.capture) begin
      idx_q      <= '0;
      tick_chg_q <= 1'b0;
    end else if (cmd_i.walk_step) begin
      idx_q      <= idx_q + NW'(1);
      tick_chg_q <= tick_chg_q || (drop != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NN; i++) begin
        cost_q[i] <= '1;
        hop_q[i]  <= '0;
        age_q[i]  <= '1;
      end
      valid_q  <= '0;
      bridge_q <= '0;
      reach_q  <= '0;
    end else begin
      if (cmd_i.walk_step) begin
        if (wnode_act) begin
          age_q[idx_q] <= age_inc;
        end
        for (int j = 0; j < NN; j++) begin
          if (drop[j]) begin
            cost_q[j]  <= cfg_i.cost_limit;
            valid_q[j] <= 1'b0;
          end
        end
      end
      if (cmd_i.finish && entry_ok) begin
        age_q[src_idx] <= '0;
        if (upd) begin
          cost_q[dst_q]  <= cand;
          hop_q[dst_q]   <= src_idx;
          valid_q[dst_q] <= 1'b1;
        end
        if (last_q) begin
          bridge_q[src_idx] <= bridge_new;
          reach_q           <= '0;
        end else begin
          reach_q <= reach_inc;
        end
      end
    end
  end

  assign changed_o     = res_changed_q;
  assign route_cost_o  = res_cost_q;
  assign next_hop_o    = res_hop_q;
  assign route_valid_o = res_valid_q;
  assign bridge_o      = res_bridge_q;
  assign ignored_o     = res_ignored_q;

endmodule

[hw/rtl/distance_vector_route_table.sv]
`timescale 1ns / 1ps

// Hop-count route table for a distance-vector node. Each accepted transaction
// is one of three kinds: a neighbor entry relaxes the route to dest_id through
// source_id (advertised cost plus one hop, clamped to the cost limit), clears
// the neighbor's age and, on last_entry, sets its bridge flag from the count of
// directly reached destinations; a tick ages every active node except self_id
// and drops all routes through nodes silent longer than timeout_ticks; a query
// reads one route and one bridge flag. Every transaction returns exactly one
// result. The block handles one transaction at a time. An entry or a query is
// captured, then committed to the result register. A tick walks all MAX_NODES
// entries of the node table one node per cycle between capture and commit. The
// input is accepted again while a finished result still waits in the output
// register; the commit waits only while that register is full and out_stall_i
// is high. Configuration lives in four APB registers at byte addresses 0
// (self_id), 4 (node_count), 8 (cost limit, the unreachable value) and 12
// (timeout_ticks); write them only while the block is idle. No clearing pass is
// needed after reset.
module distance_vector_route_table #(
  parameter int unsigned AGE_BITS = dvrt_pkg::AGE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dvrt_pkg::APB_AW-1:0]       paddr,
  input  logic [dvrt_pkg::APB_DW-1:0]       pwdata,
  output logic [dvrt_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  // Item input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [dvrt_pkg::KIND_W-1:0]       kind_i,
  input  logic [dvrt_pkg::SRC_W-1:0]        source_id_i,
  input  logic [dvrt_pkg::NODE_W-1:0]       dest_id_i,
  input  logic [dvrt_pkg::COST_BITS-1:0]    adv_cost_i,
  input  logic                              last_entry_i,
  // Result output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              changed_o,
  output logic [dvrt_pkg::COST_BITS-1:0]    route_cost_o,
  output logic [dvrt_pkg::NODE_W-1:0]       next_hop_o,
  output logic                              route_valid_o,
  output logic                              bridge_o,
  output logic                              ignored_o
);

  dvrt_pkg::cfg_t       cfg;
  dvrt_pkg::dp_cmd_t    dp_cmd;
  dvrt_pkg::dp_status_t dp_status;

  // Register file: holds self_id, node_count, the cost limit and timeout_ticks.
  dvrt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: capture, walk the table on a tick, then commit the result.
  dvrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  // Route table, ages, bridge flags and the result register.
  dvrt_dp #(
    .AGE_BITS (AGE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status),
    .kind_i        (kind_i),
    .source_id_i   (source_id_i),
    .dest_id_i     (dest_id_i),
    .adv_cost_i    (adv_cost_i),
    .last_entry_i  (last_entry_i),
    .changed_o     (changed_o),
    .route_cost_o  (route_cost_o),
    .next_hop_o    (next_hop_o),
    .route_valid_o (route_valid_o),
    .bridge_o      (bridge_o),
    .ignored_o     (ignored_o)
  );

`ifndef SYNTHESIS
  // An accepted transaction keeps the input stalled in the cycle after acceptance.
  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("input not stalled after accepting a transaction");

  // A new result is only committed from a busy cycle.
  a_result_from_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o)
  ) else $error("result appeared without a transaction in flight");

  // A dropped entry neither changes a route nor reports a bridge.
  a_ignored_is_quiet : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ignored_o) |-> (!changed_o && !bridge_o)
  ) else $error("ignored entry reports a change or a bridge flag");
`endif

endmodule
